>>> rtl/core/pip_pkg.sv
// Shared types and codes for the point-in-polygon test unit.
// No dependencies; compile before every other file of the block.
`default_nettype none

package pip_pkg;

  // Operation codes carried by the request channel
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_WALK   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  // Status from the edge evaluator back to the sequencer
  typedef struct packed {
    logic busy;    // an edge is still in the evaluator stages
    logic toggle;  // an edge crosses left of the point this cycle
  } eval_status_t;

endpackage

`default_nettype wire

>>> rtl/core/pip_if.sv
// Valid/ready channel interfaces for the point-in-polygon test unit.
// Depends on nothing; compile after pip_pkg.sv.
`default_nettype none

interface pip_req_if #(
  parameter int COORD_WIDTH = 24
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    opcode;
  logic signed [COORD_WIDTH-1:0] coord_x;
  logic signed [COORD_WIDTH-1:0] coord_y;

  modport source (output valid, opcode, coord_x, coord_y, input ready);
  modport sink   (input valid, opcode, coord_x, coord_y, output ready);
endinterface

interface pip_rsp_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic vertex_overflow;

  modport source (output valid, inside_res, vertex_overflow, input ready);
  modport sink   (input valid, inside_res, vertex_overflow, output ready);
endinterface

`default_nettype wire

>>> rtl/core/pip_edge_eval.sv
// Pipelined crossing test for one polygon edge per cycle.
// Depends on pip_pkg (status struct).
`default_nettype none

module pip_edge_eval #(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          edge_valid,
  input  wire logic signed [COORD_WIDTH-1:0] qx,
  input  wire logic signed [COORD_WIDTH-1:0] qy,
  input  wire logic signed [COORD_WIDTH-1:0] xi,
  input  wire logic signed [COORD_WIDTH-1:0] yi,
  input  wire logic signed [COORD_WIDTH-1:0] xj,
  input  wire logic signed [COORD_WIDTH-1:0] yj,
  output pip_pkg::eval_status_t              status
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  logic                 straddle;
  logic                 near_left;
  logic                 s1_v;
  logic                 s1_cnt;
  logic                 s1_dpos;
  logic signed [DW-1:0] s1_a;
  logic signed [DW-1:0] s1_b;
  logic signed [DW-1:0] s1_c;
  logic signed [DW-1:0] s1_d;
  logic                 s2_v;
  logic                 s2_cnt;
  logic                 s2_dpos;
  logic signed [PW-1:0] s2_lhs;
  logic signed [PW-1:0] s2_rhs;
  logic                 left;

  // Edge straddles the query row, and one end lies at or left of the point
  assign straddle  = ((yi < qy) && (yj >= qy)) || ((yj < qy) && (yi >= qy));
  assign near_left = (xi <= qx) || (xj <= qx);

  // Valid bits of the two stages
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= edge_valid;
      s2_v <= s1_v;
    end
  end

  // Stage 1: exact differences, one bit wider than the coordinates
  always_ff @(posedge clk) begin
    s1_cnt  <= straddle && near_left;
    s1_dpos <= yj > yi;
    s1_a    <= DW'(qy) - DW'(yi);
    s1_b    <= DW'(xj) - DW'(xi);
    s1_c    <= DW'(qx) - DW'(xi);
    s1_d    <= DW'(yj) - DW'(yi);
  end

  // Stage 2: cross-multiply instead of dividing by the edge's y extent
  always_ff @(posedge clk) begin
    s2_cnt  <= s1_cnt;
    s2_dpos <= s1_dpos;
    s2_lhs  <= PW'(s1_a) * PW'(s1_b);
    s2_rhs  <= PW'(s1_c) * PW'(s1_d);
  end

  // Flip the compare sense when the edge runs downwards
  assign left = s2_dpos ? (s2_lhs < s2_rhs) : (s2_rhs < s2_lhs);

  assign status.busy   = s1_v || s2_v;
  assign status.toggle = s2_v && s2_cnt && left;

endmodule

`default_nettype wire

>>> rtl/core/point_in_polygon_test_unit.sv
// Top level of the point-in-polygon test unit: vertex memory and query walk.
// Depends on pip_pkg, pip_req_if / pip_rsp_if and pip_edge_eval.
//
//   channel  dir  payload                          transfer when
//   req      in   opcode, coord_x, coord_y          req.valid && req.ready
//   rsp      out  inside_res, vertex_overflow       rsp.valid && rsp.ready
//
// Clear and append need no walk. A query over n stored vertices makes n + 1
// reads, one per cycle; then the drain state waits for the evaluator to empty
// and the finish state loads the result once the output register is free (a
// query with no vertices goes straight to finish), and the sequencer goes idle.
// Reset clears the vertex count and overflow flag; vertex memory is not cleared.
// All requests, clears and appends included, are held off while a walk runs and
// while its result waits for the output register to empty.
`default_nettype none

module point_in_polygon_test_unit #(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_WIDTH  = 24
) (
  input  wire logic clk,
  input  wire logic rst,
  pip_req_if.sink   req,
  pip_rsp_if.source rsp
);

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int W  = COORD_WIDTH;

  pip_pkg::state_t       state;
  pip_pkg::eval_status_t ev_status;

  logic [2*W-1:0]        mem [MAX_VERTICES];
  logic [2*W-1:0]        rdata;
  logic [CW-1:0]         count;
  logic                  overflow;
  logic [CW-1:0]         rd_cnt;
  logic [CW-1:0]         rd_addr;
  logic                  rd_issue;
  logic                  rd_v;
  logic                  rd_first;
  logic signed [W-1:0]   qx;
  logic signed [W-1:0]   qy;
  logic signed [W-1:0]   prev_x;
  logic signed [W-1:0]   prev_y;
  logic signed [W-1:0]   cur_x;
  logic signed [W-1:0]   cur_y;
  logic                  parity;
  logic                  req_xfer;
  logic                  rsp_load;
  logic                  wr_en;

  assign req.ready = (state == pip_pkg::ST_IDLE);
  assign req_xfer  = req.valid && req.ready;
  assign wr_en     = req_xfer && (req.opcode == pip_pkg::OP_APPEND) &&
                     (count < CW'(MAX_VERTICES));
  assign rsp_load  = (state == pip_pkg::ST_FINISH) && (!rsp.valid || rsp.ready);
  assign rd_issue  = (state == pip_pkg::ST_WALK);

  // Walk order: last vertex first, then vertex 0 up to the last
  assign rd_addr = (rd_cnt == '0) ? (count - CW'(1)) : (rd_cnt - CW'(1));

  // Vertex memory: one write port for appends, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[AW-1:0]] <= {req.coord_x, req.coord_y};
    end
    if (rd_issue) begin
      rdata <= mem[rd_addr[AW-1:0]];
    end
  end

  assign cur_x = rdata[2*W-1:W];
  assign cur_y = rdata[W-1:0];

  // Polygon bookkeeping: count and sticky overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (req_xfer && (req.opcode == pip_pkg::OP_CLEAR)) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (wr_en) begin
      count <= count + CW'(1);
    end else if (req_xfer && (req.opcode == pip_pkg::OP_APPEND)) begin
      overflow <= 1'b1;
    end
  end

  // Sequencer for the query walk
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= pip_pkg::ST_IDLE;
      rd_v   <= 1'b0;
      rd_cnt <= '0;
      parity <= 1'b0;
    end else begin
      rd_v <= rd_issue;
      if (ev_status.toggle) begin
        parity <= ~parity;
      end
      case (state)
        pip_pkg::ST_IDLE: begin
          if (req_xfer && (req.opcode == pip_pkg::OP_QUERY)) begin
            rd_cnt <= '0;
            parity <= 1'b0;
            state  <= (count == '0) ? pip_pkg::ST_FINISH : pip_pkg::ST_WALK;
          end
        end
        pip_pkg::ST_WALK: begin
          rd_cnt <= rd_cnt + CW'(1);
          if (rd_cnt == count) begin
            state <= pip_pkg::ST_DRAIN;
          end
        end
        pip_pkg::ST_DRAIN: begin
          if (!rd_v && !ev_status.busy) begin
            state <= pip_pkg::ST_FINISH;
          end
        end
        pip_pkg::ST_FINISH: begin
          if (rsp_load) begin
            state <= pip_pkg::ST_IDLE;
          end
        end
        default: state <= pip_pkg::ST_IDLE;
      endcase
    end
  end

  // Hold the query point, the previous vertex and the first-read marker
  always_ff @(posedge clk) begin
    if (req_xfer && (req.opcode == pip_pkg::OP_QUERY)) begin
      qx <= req.coord_x;
      qy <= req.coord_y;
    end
    rd_first <= (rd_cnt == '0);
    if (rd_v) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
  end

  pip_edge_eval #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_eval (
    .clk        (clk),
    .rst        (rst),
    .edge_valid (rd_v && !rd_first),
    .qx         (qx),
    .qy         (qy),
    .xi         (cur_x),
    .yi         (cur_y),
    .xj         (prev_x),
    .yj         (prev_y),
    .status     (ev_status)
  );

  // Output register: load on finish, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rsp_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.inside_res      <= parity;
      rsp.vertex_overflow <= overflow;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_VERTICES))
    else $error("vertex count beyond store depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    overflow |-> (count == CW'(MAX_VERTICES)))
    else $error("overflow set with room left in store");

  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == pip_pkg::ST_FINISH))
    else $error("result raised outside finish state");

  a_read_in_walk: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> $past(state == pip_pkg::ST_WALK))
    else $error("memory read outside a walk");
`endif

endmodule

`default_nettype wire
